// ===== design/hee_pkg.sv =====
// Shared types, codes and entity tables for the HTML escape encoder.
package hee_pkg;

    localparam logic [15:0] DEFAULT_MAX_OUTPUT_LENGTH = 16'd3000;
    localparam int          DEFAULT_QUEUE_DEPTH       = 4;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_R    = 8'h72;

    typedef logic [2:0] t_kind;
    typedef logic [2:0] t_idx;

    localparam t_kind KIND_PASS = 3'd0;
    localparam t_kind KIND_LT   = 3'd1;
    localparam t_kind KIND_GT   = 3'd2;
    localparam t_kind KIND_AMP  = 3'd3;
    localparam t_kind KIND_BR   = 3'd4;
    localparam t_kind KIND_END  = 3'd5;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_entry;

    function automatic t_idx entity_len(input t_kind kind);
        t_idx len;
        case (kind)
            KIND_LT:  len = 3'd4;
            KIND_GT:  len = 3'd4;
            KIND_AMP: len = 3'd5;
            KIND_BR:  len = 3'd4;
            default:  len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] entity_char(input t_kind kind, input t_idx idx,
                                               input logic [7:0] data);
        logic [7:0] ch;
        ch = data;
        case (kind)
            KIND_LT: begin
                case (idx)
                    3'd0:    ch = CH_AMP;
                    3'd1:    ch = CH_L;
                    3'd2:    ch = CH_T;
                    default: ch = CH_SEMI;
                endcase
            end
            KIND_GT: begin
                case (idx)
                    3'd0:    ch = CH_AMP;
                    3'd1:    ch = CH_G;
                    3'd2:    ch = CH_T;
                    default: ch = CH_SEMI;
                endcase
            end
            KIND_AMP: begin
                case (idx)
                    3'd0:    ch = CH_AMP;
                    3'd1:    ch = CH_A;
                    3'd2:    ch = CH_M;
                    3'd3:    ch = CH_P;
                    default: ch = CH_SEMI;
                endcase
            end
            KIND_BR: begin
                case (idx)
                    3'd0:    ch = CH_LT;
                    3'd1:    ch = CH_B;
                    3'd2:    ch = CH_R;
                    default: ch = CH_GT;
                endcase
            end
            KIND_END: ch = CH_NUL;
            default:  ch = data;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/html_escape_encoder_core.sv =====
// Top level of the HTML escape encoder: front classifier, entry queue, back expander.
// An accepted byte is first written into the entry queue; its first result word is loaded from the queue head.
// Throughput: one plain byte per cycle while the output is not stalled; an entity or <br> is expanded byte by byte.
// Entries past the limit are dropped whole; the LF of a CR-LF pair is never queued, so the back stage never sees it.
// Input is stalled only while the entry queue is full.
// Reset (synchronous, active low) clears the queue, CR flag, counters and output valid;
// the limit register returns to 3000.
module html_escape_encoder_core #(
    parameter int QUEUE_DEPTH = hee_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_output_length,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_post_done,
    output logic        o_too_long
);

    hee_pkg::t_entry w_push_entry;
    hee_pkg::t_entry w_head_entry;
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;

    assign o_cfg_ready = 1'b1;

    hee_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .o_in_ready (o_in_ready),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    hee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_empty (w_empty)
    );

    hee_back u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_valid             (i_cfg_valid),
        .i_cfg_max_output_length (i_cfg_max_output_length),
        .i_entry                 (w_head_entry),
        .i_empty                 (w_empty),
        .o_pop                   (w_pop),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_out_byte              (o_out_byte),
        .o_run_last              (o_run_last),
        .o_post_done             (o_post_done),
        .o_too_long              (o_too_long)
    );

endmodule

// ===== design/hee_front.sv =====
// Input stage: accepts bytes, tracks CR, classifies each byte into a queue entry.
module hee_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [7:0]     i_in_byte,
    output logic           o_in_ready,
    input  logic           i_full,
    output logic           o_push,
    output hee_pkg::t_entry o_entry
);

    logic r_cr_pending;
    logic n_cr_pending;
    logic w_accept;
    logic w_skip;

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && !i_full;
    assign w_skip     = (i_in_byte == hee_pkg::CH_LF) && r_cr_pending;
    assign o_push     = w_accept && !w_skip;

    always_comb begin
        o_entry.data = i_in_byte;
        case (i_in_byte)
            hee_pkg::CH_NUL: o_entry.kind = hee_pkg::KIND_END;
            hee_pkg::CH_LT:  o_entry.kind = hee_pkg::KIND_LT;
            hee_pkg::CH_GT:  o_entry.kind = hee_pkg::KIND_GT;
            hee_pkg::CH_AMP: o_entry.kind = hee_pkg::KIND_AMP;
            hee_pkg::CH_CR:  o_entry.kind = hee_pkg::KIND_BR;
            hee_pkg::CH_LF:  o_entry.kind = hee_pkg::KIND_BR;
            default:         o_entry.kind = hee_pkg::KIND_PASS;
        endcase
    end

    always_comb begin
        n_cr_pending = r_cr_pending;
        if (w_accept) begin
            n_cr_pending = (i_in_byte == hee_pkg::CH_CR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_pending <= 1'b0;
        end else begin
            r_cr_pending <= n_cr_pending;
        end
    end

endmodule

// ===== design/hee_queue.sv =====
// Small FIFO of classified entries between front and back stages.
module hee_queue #(
    parameter int DEPTH = hee_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hee_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output hee_pkg::t_entry o_entry,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hee_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/hee_back.sv =====
// Output stage: expands entries into words, enforces the length limit, reports end of post.
module hee_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [15:0]     i_cfg_max_output_length,
    input  hee_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_post_done,
    output logic            o_too_long
);

    logic [15:0]   r_max;
    logic [15:0]   r_count;
    logic [15:0]   n_count;
    logic          r_ovf;
    logic          n_ovf;
    hee_pkg::t_idx r_idx;
    hee_pkg::t_idx n_idx;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [7:0]    r_out_byte;
    logic [7:0]    n_out_byte;
    logic          r_run_last;
    logic          n_run_last;
    logic          r_post_done;
    logic          n_post_done;
    logic          r_too_long;
    logic          n_too_long;

    logic          w_can_load;
    logic          w_last_byte;
    logic          w_limit_hit;
    hee_pkg::t_idx w_len;

    assign w_len       = hee_pkg::entity_len(i_entry.kind);
    assign w_can_load  = !r_out_valid || i_out_ready;
    assign w_last_byte = (r_idx == w_len - 3'd1);
    assign w_limit_hit = ((r_count + 16'd1) == r_max);

    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_run_last  = r_run_last;
        n_post_done = r_post_done;
        n_too_long  = r_too_long;
        if (!i_empty && w_can_load) begin
            if (i_entry.kind == hee_pkg::KIND_END) begin
                n_out_valid = 1'b1;
                n_out_byte  = hee_pkg::CH_NUL;
                n_run_last  = 1'b1;
                n_post_done = 1'b1;
                n_too_long  = r_ovf;
                n_count     = '0;
                n_ovf       = 1'b0;
                n_idx       = '0;
                o_pop       = 1'b1;
            end else if (r_count < r_max) begin
                n_out_valid = 1'b1;
                n_out_byte  = hee_pkg::entity_char(i_entry.kind, r_idx, i_entry.data);
                n_run_last  = w_last_byte || w_limit_hit;
                n_post_done = 1'b0;
                n_too_long  = 1'b0;
                n_count     = r_count + 16'd1;
                if (w_last_byte) begin
                    n_idx = '0;
                    o_pop = 1'b1;
                end else if (w_limit_hit) begin
                    n_ovf = 1'b1;
                    n_idx = '0;
                    o_pop = 1'b1;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end else begin
                // drop the whole entry
                n_ovf = 1'b1;
                n_idx = '0;
                o_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= hee_pkg::DEFAULT_MAX_OUTPUT_LENGTH;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_max_output_length;
            end
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_run_last  <= n_run_last;
        r_post_done <= n_post_done;
        r_too_long  <= n_too_long;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_post_done = r_post_done;
    assign o_too_long  = r_too_long;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_post_done |-> r_run_last)
        else $error("end-of-post word without run_last");

    a_too_long_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_too_long |-> r_post_done)
        else $error("too_long set on a data word");

    a_mid_entry_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != '0 |-> !i_empty)
        else $error("expansion in progress with empty queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

endmodule
